[hdl/blm_pkg.sv]
package blm_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int RING_DEPTH  = 10;
    localparam int DROPPED_LOW = 3;
    localparam int DECIMATION  = 5;
    localparam int KEEP_COUNT  = RING_DEPTH - DROPPED_LOW;

    localparam int RING_IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int PHASE_W    = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
    localparam int SUM_W      = $clog2((2 ** SAMPLE_BITS - 1) * RING_DEPTH + 1);

    // truncated mean of the kept values as (sum * MEAN_RECIP) >> MEAN_SHIFT;
    // the rounding error stays below one for every kept sum
    localparam int KEEP_SUM_W = $clog2((2 ** SAMPLE_BITS - 1) * KEEP_COUNT + 1);
    localparam int MEAN_SHIFT = KEEP_SUM_W + $clog2(KEEP_COUNT);
    localparam int RECIP_W    = KEEP_SUM_W + 1;
    localparam int PROD_W     = MEAN_SHIFT + SAMPLE_BITS;
    localparam logic [RECIP_W-1:0] MEAN_RECIP =
        RECIP_W'((2 ** MEAN_SHIFT + KEEP_COUNT - 1) / KEEP_COUNT);

    localparam int LEVEL_W    = 3;
    localparam int CNT_W      = 5;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 3;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX     = 3'd4;
    localparam logic [CNT_W-1:0]   LOW_CNT_RESET = 5'd5;

    localparam logic [SAMPLE_BITS-1:0] THR_ONE_RESET   = 12'd2500;
    localparam logic [SAMPLE_BITS-1:0] THR_TWO_RESET   = 12'd2650;
    localparam logic [SAMPLE_BITS-1:0] THR_THREE_RESET = 12'd2800;
    localparam logic [SAMPLE_BITS-1:0] THR_FOUR_RESET  = 12'd3030;
    localparam logic [SAMPLE_BITS-1:0] JITTER_RESET    = 12'd5;
    localparam logic [CNT_W-1:0]       ALARM_RELOAD_RESET = 5'd20;
    localparam logic [CNT_W-1:0]       RECOVERY_RESET     = 5'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD_ONE   = 3'd0,
        REG_THRESHOLD_TWO   = 3'd1,
        REG_THRESHOLD_THREE = 3'd2,
        REG_THRESHOLD_FOUR  = 3'd3,
        REG_JITTER_LIMIT    = 3'd4,
        REG_ALARM_RELOAD    = 3'd5,
        REG_RECOVERY_COUNT  = 3'd6
    } blm_reg_idx_t;

    // controller -> datapath
    typedef struct packed {
        logic                  accept;
        logic                  scan_en;
        logic [RING_IDX_W-1:0] scan_idx;
        logic                  div_load;
        logic                  div_step;
        logic                  finish;
    } blm_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic eval_due;
    } blm_status_t;

endpackage

[hdl/battery_level_monitor.sv]
// Battery level monitor. Each transfer on the input stream carries one 12-bit
// ADC sample and the charger flag; each one yields exactly one transfer on the
// output stream. Samples go into a 10-entry ring (cleared at reset). Every
// fifth sample starts an evaluation: the controller scans the ring one entry
// per cycle, summing it and tracking the three smallest values, then the sum
// of the seven kept values is formed and a reciprocal multiplication gives
// their truncated mean. If the mean moves from the held value by more than
// the jitter limit, the held value and the level (0..4, from four thresholds
// checked in order) are replaced; the low power countdown then steps. A
// sample that does not start an evaluation is answered on the cycle after its
// transfer. An evaluating sample is answered after the ring scan, the kept
// sum, the multiply and the level and countdown update, in that order, and
// the input is held off for the whole evaluation. A new sample is taken
// once the block is idle and the output register is empty or being emptied.
// Configuration writes are always ready and must be issued while the block
// is idle; indexes 0..6 map to threshold_one..four, jitter_limit,
// alarm_reload and recovery_count, index 7 is ignored.
module battery_level_monitor
    import blm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [11:0] sample, [15:12] zero
    input  logic [0:0]            s_tuser,   // [0] charging
    // output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // [2:0] level, [3] filter_done,
                                             // [15:4] filtered_mean,
                                             // [16] level_updated,
                                             // [17] low_power_alarm, [23:18] zero
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    blm_cmd_t               cmd;
    blm_status_t            status;
    logic [LEVEL_W-1:0]     level;
    logic                   filter_done;
    logic [SAMPLE_BITS-1:0] filtered_mean;
    logic                   level_updated;
    logic                   low_power_alarm;

    // registers are plain flops, a write always completes
    assign cfg_ready = 1'b1;

    blm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    blm_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .sample          (s_tdata[SAMPLE_BITS-1:0]),
        .charging        (s_tuser[0]),
        .cfg_write       (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .level           (level),
        .filter_done     (filter_done),
        .filtered_mean   (filtered_mean),
        .level_updated   (level_updated),
        .low_power_alarm (low_power_alarm)
    );

    assign m_tdata = {6'd0, low_power_alarm, level_updated, filtered_mean,
                      filter_done, level};

endmodule

[hdl/blm_ctrl.sv]
module blm_ctrl
    import blm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  blm_status_t status,
    output blm_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PREP,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    state_t                state_reg;
    logic [RING_IDX_W-1:0] scan_idx_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  accept;

    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.accept   = accept;
        cmd.scan_en  = (state_reg == ST_SCAN);
        cmd.scan_idx = scan_idx_reg;
        cmd.div_load = (state_reg == ST_PREP);
        cmd.div_step = (state_reg == ST_DIVIDE);
        cmd.finish   = (state_reg == ST_FINISH);
    end

    // result register: emptied by a transfer, filled by a plain sample or a finish
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if ((accept && !status.eval_due) || state_reg == ST_FINISH)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && status.eval_due)
                    begin
                        state_reg    <= ST_SCAN;
                        scan_idx_reg <= '0;
                    end
                end
                ST_SCAN:
                begin
                    if (scan_idx_reg == RING_IDX_W'(RING_DEPTH - 1))
                        state_reg <= ST_PREP;
                    else
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                ST_PREP:
                begin
                    state_reg <= ST_DIVIDE;
                end
                ST_DIVIDE:
                begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // an evaluation must never overwrite a result still waiting downstream
    a_finish_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FINISH |-> !out_valid_reg)
        else $error("evaluation finished while output register occupied");

    a_finish_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FINISH |=> out_valid_reg)
        else $error("evaluation result not presented");

    a_eval_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept && status.eval_due |=> state_reg == ST_SCAN && scan_idx_reg == '0)
        else $error("evaluation transfer did not start a ring scan");

    a_scan_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN && scan_idx_reg == RING_IDX_W'(RING_DEPTH - 1)
        |=> state_reg == ST_PREP)
        else $error("ring scan did not end after last entry");

endmodule

[hdl/blm_datapath.sv]
module blm_datapath
    import blm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  blm_cmd_t               cmd,
    output blm_status_t            status,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   charging,
    input  logic                   cfg_write,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic [LEVEL_W-1:0]     level,
    output logic                   filter_done,
    output logic [SAMPLE_BITS-1:0] filtered_mean,
    output logic                   level_updated,
    output logic                   low_power_alarm
);

    // configuration
    logic [SAMPLE_BITS-1:0] thr_one_reg, thr_two_reg, thr_three_reg, thr_four_reg;
    logic [SAMPLE_BITS-1:0] jitter_reg;
    logic [CNT_W-1:0]       alarm_reload_reg, recovery_reg;

    // filter state
    logic [SAMPLE_BITS-1:0] ring_reg [RING_DEPTH];
    logic [RING_IDX_W-1:0]  ring_pos_reg;
    logic [PHASE_W-1:0]     phase_reg;
    logic [SAMPLE_BITS-1:0] held_reg;
    logic [LEVEL_W-1:0]     level_reg;
    logic [CNT_W-1:0]       low_cnt_reg;
    logic                   charging_reg;

    // evaluation working registers
    logic [SUM_W-1:0]       sum_reg;
    logic [SAMPLE_BITS-1:0] low_reg [DROPPED_LOW];
    logic [SAMPLE_BITS-1:0] low_next [DROPPED_LOW];
    logic [KEEP_SUM_W-1:0]  keep_sum_reg;
    logic [SAMPLE_BITS-1:0] mean_reg;

    // output register
    logic [LEVEL_W-1:0]     out_level_reg;
    logic                   out_done_reg;
    logic [SAMPLE_BITS-1:0] out_mean_reg;
    logic                   out_upd_reg;
    logic                   out_alarm_reg;

    logic [SAMPLE_BITS-1:0] scan_val;
    logic [SUM_W-1:0]       low_sum;
    logic [PROD_W-1:0]      mean_prod;
    logic [SAMPLE_BITS-1:0] mean;
    logic [SAMPLE_BITS-1:0] diff;
    logic                   upd;
    logic [LEVEL_W-1:0]     lvl_class;
    logic [LEVEL_W-1:0]     lvl_next;
    logic [CNT_W-1:0]       low_cnt_next;
    logic                   alarm;

    assign status.eval_due = (phase_reg == PHASE_W'(DECIMATION - 1));
    assign scan_val = ring_reg[cmd.scan_idx];

    // keep the DROPPED_LOW smallest values seen, ascending
    always_comb
    begin
        for (int k = 0; k < DROPPED_LOW; k++)
        begin
            if (scan_val < low_reg[k])
            begin
                if (k == 0)
                    low_next[k] = scan_val;
                else if (scan_val < low_reg[k-1])
                    low_next[k] = low_reg[k-1];
                else
                    low_next[k] = scan_val;
            end
            else
            begin
                low_next[k] = low_reg[k];
            end
        end
    end

    always_comb
    begin
        low_sum = '0;
        for (int k = 0; k < DROPPED_LOW; k++)
            low_sum = low_sum + SUM_W'(low_reg[k]);
    end

    // divide by the keep count through a reciprocal multiply
    assign mean_prod = PROD_W'(keep_sum_reg) * PROD_W'(MEAN_RECIP);

    assign mean = mean_reg;
    assign diff = (mean > held_reg) ? (mean - held_reg) : (held_reg - mean);
    assign upd  = (diff > jitter_reg);

    // level counts thresholds passed in order, stopping at the first miss
    always_comb
    begin
        lvl_class = '0;
        if (mean > thr_one_reg)
        begin
            lvl_class = 3'd1;
            if (mean > thr_two_reg)
            begin
                lvl_class = 3'd2;
                if (mean > thr_three_reg)
                begin
                    lvl_class = 3'd3;
                    if (mean > thr_four_reg)
                        lvl_class = LEVEL_MAX;
                end
            end
        end
    end

    always_comb
    begin
        lvl_next     = upd ? lvl_class : level_reg;
        alarm        = 1'b0;
        low_cnt_next = recovery_reg;
        if (lvl_next == '0 && !charging_reg)
        begin
            if (low_cnt_reg != '0)
            begin
                low_cnt_next = low_cnt_reg - 1'b1;
            end
            else
            begin
                alarm        = 1'b1;
                low_cnt_next = alarm_reload_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_one_reg      <= THR_ONE_RESET;
            thr_two_reg      <= THR_TWO_RESET;
            thr_three_reg    <= THR_THREE_RESET;
            thr_four_reg     <= THR_FOUR_RESET;
            jitter_reg       <= JITTER_RESET;
            alarm_reload_reg <= ALARM_RELOAD_RESET;
            recovery_reg     <= RECOVERY_RESET;
            for (int i = 0; i < RING_DEPTH; i++)
                ring_reg[i] <= '0;
            ring_pos_reg <= '0;
            phase_reg    <= '0;
            held_reg     <= '0;
            level_reg    <= '0;
            low_cnt_reg  <= LOW_CNT_RESET;
            charging_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_THRESHOLD_ONE:   thr_one_reg   <= cfg_data[SAMPLE_BITS-1:0];
                    REG_THRESHOLD_TWO:   thr_two_reg   <= cfg_data[SAMPLE_BITS-1:0];
                    REG_THRESHOLD_THREE: thr_three_reg <= cfg_data[SAMPLE_BITS-1:0];
                    REG_THRESHOLD_FOUR:  thr_four_reg  <= cfg_data[SAMPLE_BITS-1:0];
                    REG_JITTER_LIMIT:    jitter_reg    <= cfg_data[SAMPLE_BITS-1:0];
                    REG_ALARM_RELOAD:    alarm_reload_reg <= cfg_data[CNT_W-1:0];
                    REG_RECOVERY_COUNT:  recovery_reg     <= cfg_data[CNT_W-1:0];
                    default:             ;
                endcase
            end
            if (cmd.accept)
            begin
                ring_reg[ring_pos_reg] <= sample;
                ring_pos_reg <= (ring_pos_reg == RING_IDX_W'(RING_DEPTH - 1)) ?
                                '0 : ring_pos_reg + 1'b1;
                phase_reg    <= status.eval_due ? '0 : phase_reg + 1'b1;
                charging_reg <= charging;
            end
            if (cmd.finish)
            begin
                if (upd)
                    held_reg <= mean;
                level_reg   <= lvl_next;
                low_cnt_reg <= low_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && status.eval_due)
        begin
            sum_reg <= '0;
            for (int k = 0; k < DROPPED_LOW; k++)
                low_reg[k] <= '1;
        end
        else if (cmd.scan_en)
        begin
            sum_reg <= sum_reg + SUM_W'(scan_val);
            for (int k = 0; k < DROPPED_LOW; k++)
                low_reg[k] <= low_next[k];
        end

        if (cmd.div_load)
            keep_sum_reg <= KEEP_SUM_W'(sum_reg - low_sum);

        if (cmd.div_step)
            mean_reg <= mean_prod[PROD_W-1:MEAN_SHIFT];

        if (cmd.accept && !status.eval_due)
        begin
            out_level_reg <= level_reg;
            out_done_reg  <= 1'b0;
            out_mean_reg  <= '0;
            out_upd_reg   <= 1'b0;
            out_alarm_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_level_reg <= lvl_next;
            out_done_reg  <= 1'b1;
            out_mean_reg  <= mean;
            out_upd_reg   <= upd;
            out_alarm_reg <= alarm;
        end
    end

    assign level           = out_level_reg;
    assign filter_done     = out_done_reg;
    assign filtered_mean   = out_mean_reg;
    assign level_updated   = out_upd_reg;
    assign low_power_alarm = out_alarm_reg;

endmodule

[dv/blm_checker.sv]
`timescale 1ns / 100ps

// Watches the sample, result and register write channels, keeps its own copy of
// the monitor state and compares every result transfer with the oldest prediction.
module blm_checker
    import blm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [11:0] sample, [15:12] zero
    input  logic [0:0]            s_tuser,   // [0] charging
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [23:0]           m_tdata,   // [2:0] level, [3] filter_done,
                                             // [15:4] filtered_mean,
                                             // [16] level_updated,
                                             // [17] low_power_alarm, [23:18] zero
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    pending,
    output int                    mismatches
);

    localparam int NUM_THRESHOLDS = 4;

    typedef struct packed {
        logic [LEVEL_W-1:0]     level;
        logic                   filter_done;
        logic [SAMPLE_BITS-1:0] mean;
        logic                   level_updated;
        logic                   low_power_alarm;
    } level_report_t;

    level_report_t expected_reports[$];
    int            err_total;

    // shadow registers
    logic [SAMPLE_BITS-1:0] thr [NUM_THRESHOLDS];
    logic [SAMPLE_BITS-1:0] jitter;
    logic [CNT_W-1:0]       alarm_reload;
    logic [CNT_W-1:0]       recovery;

    // shadow state
    logic [SAMPLE_BITS-1:0] ring [RING_DEPTH];
    int unsigned            ring_wr;
    int unsigned            phase;
    logic [SAMPLE_BITS-1:0] held;
    logic [LEVEL_W-1:0]     cur_level;
    logic [CNT_W-1:0]       lp_count;

    // mean of the ring with the DROPPED_LOW smallest entries removed
    function automatic logic [SAMPLE_BITS-1:0] trimmed_ring_mean();
        logic [SAMPLE_BITS-1:0] sorted [RING_DEPTH];
        logic [SAMPLE_BITS-1:0] v;
        int                     j;
        int unsigned            sum;
        sorted = ring;
        sum = 0;
        for (int i = 1; i < RING_DEPTH; i++)
        begin
            v = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] < v)
            begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end
        for (int i = 0; i < KEEP_COUNT; i++)
            sum += sorted[i];
        return SAMPLE_BITS'(sum / KEEP_COUNT);
    endfunction

    // thresholds checked in order, stop at the first one not exceeded
    function automatic logic [LEVEL_W-1:0] level_for(input logic [SAMPLE_BITS-1:0] v);
        int n;
        n = 0;
        while (n < NUM_THRESHOLDS && v > thr[n])
            n++;
        return LEVEL_W'(n);
    endfunction

    function automatic level_report_t advance_monitor(input logic [SAMPLE_BITS-1:0] smp,
                                                      input logic chg);
        level_report_t          r;
        logic [SAMPLE_BITS-1:0] m;
        logic [SAMPLE_BITS-1:0] gap;
        r = '0;
        ring[ring_wr] = smp;
        ring_wr = (ring_wr == RING_DEPTH - 1) ? 0 : ring_wr + 1;
        phase++;
        if (phase >= DECIMATION)
        begin
            phase = 0;
            r.filter_done = 1'b1;
            m = trimmed_ring_mean();
            r.mean = m;
            gap = (m > held) ? m - held : held - m;
            if (gap > jitter)
            begin
                held = m;
                cur_level = level_for(m);
                r.level_updated = 1'b1;
            end
            if (cur_level == 0 && !chg)
            begin
                if (lp_count != 0)
                    lp_count--;
                else
                begin
                    r.low_power_alarm = 1'b1;
                    lp_count = alarm_reload;
                end
            end
            else
                lp_count = recovery;
        end
        r.level = cur_level;
        return r;
    endfunction

    task automatic check_field(input string what, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v)
        begin
            err_total++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        level_report_t want;
        if (!rst_n)
        begin
            thr[0]       = THR_ONE_RESET;
            thr[1]       = THR_TWO_RESET;
            thr[2]       = THR_THREE_RESET;
            thr[3]       = THR_FOUR_RESET;
            jitter       = JITTER_RESET;
            alarm_reload = ALARM_RELOAD_RESET;
            recovery     = RECOVERY_RESET;
            for (int k = 0; k < RING_DEPTH; k++)
                ring[k] = '0;
            ring_wr   = 0;
            phase     = 0;
            held      = '0;
            cur_level = '0;
            lp_count  = LOW_CNT_RESET;
            expected_reports.delete();
            err_total = 0;
            pending    <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_THRESHOLD_ONE:   thr[0] = cfg_data;
                    REG_THRESHOLD_TWO:   thr[1] = cfg_data;
                    REG_THRESHOLD_THREE: thr[2] = cfg_data;
                    REG_THRESHOLD_FOUR:  thr[3] = cfg_data;
                    REG_JITTER_LIMIT:    jitter = cfg_data;
                    REG_ALARM_RELOAD:    alarm_reload = cfg_data[CNT_W-1:0];
                    REG_RECOVERY_COUNT:  recovery = cfg_data[CNT_W-1:0];
                    default:             ;
                endcase
            end

            // retire before predicting so a stray result never matches a new sample
            if (m_tvalid && m_tready)
            begin
                if (expected_reports.size() == 0)
                begin
                    err_total++;
                    $display("%0t: unexpected result, expected none, actual tdata %h",
                             $time, m_tdata);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("level",           want.level,           m_tdata[2:0]);
                    check_field("filter_done",     want.filter_done,     m_tdata[3]);
                    check_field("filtered_mean",   want.mean,            m_tdata[15:4]);
                    check_field("level_updated",   want.level_updated,   m_tdata[16]);
                    check_field("low_power_alarm", want.low_power_alarm, m_tdata[17]);
                    check_field("tdata padding",   0,                    m_tdata[23:18]);
                end
            end

            if (s_tvalid && s_tready)
                expected_reports.push_back(advance_monitor(s_tdata[SAMPLE_BITS-1:0],
                                                           s_tuser[0]));

            pending    <= expected_reports.size();
            mismatches <= err_total;
        end
    end

endmodule

[dv/battery_level_monitor_tb.sv]
`timescale 1ns / 100ps

// Stimulus and verdict. All checking lives in blm_checker.
module battery_level_monitor_tb;

    import blm_pkg::*;

    localparam int DIRECTED_COUNT   = 25;
    localparam int NUM_SETTINGS     = 8;
    localparam int RANDOM_PER_PHASE = 166;
    localparam int IDLE_PCT         = 8;      // idle cycles per hundred, each side
    localparam int QUIET_FIRST      = 700;    // no idling on either side in this window
    localparam int QUIET_LAST       = 900;
    localparam int HOLD_START       = 300;    // receiver back-pressure kicks in here
    localparam int HOLD_CYCLES      = 400;
    localparam int END_PAUSE        = 40;
    localparam int CYCLE_LIMIT      = 500000;

    // index past the register file, the block must ignore it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [15:0]           s_tdata;   // [11:0] sample, [15:12] zero
    logic [0:0]            s_tuser;   // [0] charging
    logic                  m_tvalid;
    logic                  m_tready;
    logic [23:0]           m_tdata;   // [2:0] level, [3] filter_done, [15:4] filtered_mean,
                                      // [16] level_updated, [17] low_power_alarm, [23:18] zero
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int pending;
    int mismatches;
    int sent_count;
    int cycle_count;

    // thresholds in force, so random runs can straddle them
    int cur_thr [4];

    // random run shaping
    int   run_left;
    int   run_base;
    logic run_chg;

    battery_level_monitor i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    blm_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .mismatches (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit in_quiet_window();
        return sent_count >= QUIET_FIRST && sent_count < QUIET_LAST;
    endfunction

    // One sample transfer. Called at a clock edge, returns at the accepting edge
    // with tvalid still high, so back-to-back samples never drop it in between.
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp, input logic chg);
        if (!in_quiet_window())
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(16 - SAMPLE_BITS){1'b0}}, smp};
        s_tuser  <= chg;
        do
            @(posedge clk);
        while (!s_tready);
        sent_count++;
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Stop offering and wait until every result transfer has come back. The
    // first edge lets the checker's count catch up with the last transfer.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Register settings per phase: typical, all-zero and all-ones extremes,
    // thresholds out of order, random, and the reset values written back.
    task automatic apply_setting(input int p);
        logic [SAMPLE_BITS-1:0] t [4];
        logic [SAMPLE_BITS-1:0] j;
        logic [CNT_W-1:0]       ar;
        logic [CNT_W-1:0]       rc;
        case (p)
            0:
            begin
                t = '{12'd1000, 12'd1800, 12'd2600, 12'd3400};
                j = 12'd20;   ar = 5'd3;  rc = 5'd4;
            end
            1:
            begin
                t = '{12'd0, 12'd0, 12'd0, 12'd0};
                j = 12'd0;    ar = 5'd0;  rc = 5'd0;
            end
            2:
            begin
                t = '{12'd4095, 12'd4095, 12'd4095, 12'd4095};
                j = 12'd4095; ar = 5'd31; rc = 5'd31;
            end
            3:
            begin
                // descending pairs: level stops at the first miss
                t = '{12'd3000, 12'd1000, 12'd3500, 12'd2000};
                j = 12'd1;    ar = 5'd2;  rc = 5'd1;
            end
            4:
            begin
                for (int i = 0; i < 4; i++)
                    t[i] = SAMPLE_BITS'($urandom_range(4095));
                j  = SAMPLE_BITS'($urandom_range(63));
                ar = CNT_W'($urandom_range(31));
                rc = CNT_W'($urandom_range(31));
            end
            5:
            begin
                t[0] = SAMPLE_BITS'($urandom_range(1500));
                for (int i = 1; i < 4; i++)
                    t[i] = t[i-1] + SAMPLE_BITS'($urandom_range(800));
                j  = SAMPLE_BITS'($urandom_range(40));
                ar = CNT_W'($urandom_range(6));
                rc = CNT_W'($urandom_range(31));
            end
            6:
            begin
                t = '{THR_ONE_RESET, THR_TWO_RESET, THR_THREE_RESET, THR_FOUR_RESET};
                j = JITTER_RESET; ar = ALARM_RELOAD_RESET; rc = RECOVERY_RESET;
            end
            default:
            begin
                for (int i = 0; i < 4; i++)
                    t[i] = SAMPLE_BITS'($urandom_range(4095));
                j  = SAMPLE_BITS'($urandom_range(4095));
                ar = CNT_W'($urandom_range(31));
                rc = CNT_W'($urandom_range(31));
            end
        endcase
        for (int i = 0; i < 4; i++)
            cur_thr[i] = int'(t[i]);
        write_reg(REG_THRESHOLD_ONE,   t[0]);
        write_reg(REG_THRESHOLD_TWO,   t[1]);
        write_reg(REG_UNUSED,          CFG_DATA_W'($urandom_range(4095)));
        write_reg(REG_THRESHOLD_THREE, t[2]);
        write_reg(REG_THRESHOLD_FOUR,  t[3]);
        write_reg(REG_JITTER_LIMIT,    j);
        // junk in the upper bits of the 5-bit registers must be masked off
        write_reg(REG_ALARM_RELOAD,    {7'($urandom_range(127)), ar});
        write_reg(REG_RECOVERY_COUNT,  {7'($urandom_range(127)), rc});
        cfg_valid <= 1'b0;
    endtask

    // Runs of samples around a level (a threshold, deep discharge, or anywhere)
    // with a steady charger flag, plus a sprinkling of fully random noise.
    task automatic run_random(input int count);
        int v;
        repeat (count)
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(40, 8);
                case ($urandom_range(3))
                    0, 1:    run_base = cur_thr[$urandom_range(3)];
                    2:       run_base = $urandom_range(400);
                    default: run_base = $urandom_range(4095);
                endcase
                run_chg = ($urandom_range(3) == 0);
            end
            run_left--;
            if ($urandom_range(9) == 0)
                send_sample(SAMPLE_BITS'($urandom_range(4095)), 1'($urandom_range(1)));
            else
            begin
                v = run_base + int'($urandom_range(24)) - 12;
                if (v < 0)
                    v = 0;
                if (v > 4095)
                    v = 4095;
                send_sample(v[SAMPLE_BITS-1:0], run_chg);
            end
        end
    endtask

    // main stimulus and verdict
    initial
    begin
        rst_n      <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        sent_count  = 0;
        run_left    = 0;
        run_base    = 0;
        run_chg     = 1'b0;
        cur_thr     = '{int'(THR_ONE_RESET), int'(THR_TWO_RESET),
                        int'(THR_THREE_RESET), int'(THR_FOUR_RESET)};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset settings: full scale into a half-zero ring, a charging
        // run that leaves the mean unchanged, a drop to zero, then a ring full
        // of full-scale samples for the largest possible sum.
        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            if (i < 5)
                send_sample(12'd4095, 1'b0);
            else if (i < 10)
                send_sample(12'd0, 1'b1);
            else if (i < 15)
                send_sample(12'd0, 1'b0);
            else
                send_sample(12'd4095, i[0]);
        end
        drain_results();

        // register writes only while the block is idle
        for (int p = 0; p < NUM_SETTINGS; p++)
        begin
            apply_setting(p);
            run_random(RANDOM_PER_PHASE);
            drain_results();
        end

        repeat (END_PAUSE) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: random back-pressure, a quiet window, and one long hold-off
    // while the sender keeps offering so the block fills and stalls its input
    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!hold_done && sent_count >= HOLD_START)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (in_quiet_window())
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[sim.f]
hdl/blm_pkg.sv
hdl/blm_ctrl.sv
hdl/blm_datapath.sv
hdl/battery_level_monitor.sv
dv/blm_checker.sv
dv/battery_level_monitor_tb.sv
